@@ rtl/scl_pkg.sv @@
package scl_pkg;

    localparam int OP_W        = 2;
    localparam int SYM_W       = 8;
    localparam int TGT_W       = 6;
    localparam int LEN_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [OP_W-1:0] OP_APPEND_FIRST  = 2'd0;
    localparam logic [OP_W-1:0] OP_APPEND_SECOND = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY         = 2'd2;

    typedef enum logic [1:0] {
        CMD_APPEND_FIRST,
        CMD_APPEND_SECOND,
        CMD_QUERY
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t          kind;
        logic [SYM_W-1:0]   symbol;
        logic [TGT_W-1:0]   target;
    } cmd_t;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } eng_state_t;

endpackage

@@ rtl/scl_in_if.sv @@
interface scl_in_if import scl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    operation;
    logic [SYM_W-1:0]   symbol;
    logic [TGT_W-1:0]   target_common;

    modport source (output valid, output operation, output symbol, output target_common,
                    input ready);
    modport sink   (input valid, input operation, input symbol, input target_common,
                    output ready);
endinterface

@@ rtl/scl_out_if.sv @@
interface scl_out_if import scl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               reachable;
    logic [LEN_W-1:0]   super_length;
    logic               overflow;

    modport source (output valid, output reachable, output super_length, output overflow,
                    input ready);
    modport sink   (input valid, input reachable, input super_length, input overflow,
                    output ready);
endinterface

@@ rtl/scl_front.sv @@
module scl_front import scl_pkg::*; (
    scl_in_if.sink  items,
    input  logic    full,
    output logic    push,
    output cmd_t    push_cmd
);

    assign items.ready = !full;

    always_comb
    begin
        push_cmd.symbol = items.symbol;
        push_cmd.target = items.target_common;
        push_cmd.kind   = CMD_QUERY;
        push            = 1'b0;
        case (items.operation)
            OP_APPEND_FIRST:
            begin
                push_cmd.kind = CMD_APPEND_FIRST;
                push          = items.valid && !full;
            end
            OP_APPEND_SECOND:
            begin
                push_cmd.kind = CMD_APPEND_SECOND;
                push          = items.valid && !full;
            end
            OP_QUERY:
            begin
                push_cmd.kind = CMD_QUERY;
                push          = items.valid && !full;
            end
            default:
            begin
                // drop the unused code
                push = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/scl_queue.sv @@
module scl_queue import scl_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  cmd_t    push_cmd,
    output logic    full,
    output logic    head_valid,
    output cmd_t    head_cmd,
    input  logic    pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_W'(QUEUE_DEPTH)))
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

@@ rtl/scl_engine.sv @@
module scl_engine import scl_pkg::*; #(
    parameter int MAX_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    input  cmd_t        cmd,
    output logic        cmd_pop,
    scl_out_if.source   results
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int IDX_W = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    eng_state_t         state_reg;
    eng_state_t         state_next;

    logic [SYM_W-1:0]   a_line_reg [MAX_LEN];
    logic [SYM_W-1:0]   a_line_next [MAX_LEN];
    logic [SYM_W-1:0]   b_line_reg [MAX_LEN];
    logic [SYM_W-1:0]   b_line_next [MAX_LEN];
    logic [CNT_W-1:0]   row_reg [MAX_LEN];
    logic [CNT_W-1:0]   row_next [MAX_LEN];

    logic [CNT_W-1:0]   m_reg;
    logic [CNT_W-1:0]   m_next;
    logic [CNT_W-1:0]   n_reg;
    logic [CNT_W-1:0]   n_next;
    logic               drop_reg;
    logic               drop_next;
    logic [CNT_W-1:0]   row_idx_reg;
    logic [CNT_W-1:0]   row_idx_next;
    logic [CNT_W-1:0]   col_reg;
    logic [CNT_W-1:0]   col_next;
    logic [CNT_W-1:0]   diag_reg;
    logic [CNT_W-1:0]   diag_next;
    logic [CNT_W-1:0]   left_reg;
    logic [CNT_W-1:0]   left_next;
    logic [TGT_W-1:0]   target_reg;
    logic [TGT_W-1:0]   target_next;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic               reach_reg;
    logic               reach_next;
    logic [LEN_W-1:0]   len_reg;
    logic [LEN_W-1:0]   len_next;
    logic               over_reg;
    logic               over_next;

    logic [CNT_W-1:0]   up;
    logic [CNT_W-1:0]   cur;
    logic               match;
    logic               sweep_ok;

    assign results.valid        = out_valid_reg;
    assign results.reachable    = reach_reg;
    assign results.super_length = len_reg;
    assign results.overflow     = over_reg;

    assign up       = row_reg[0];
    assign match    = (a_line_reg[0] == b_line_reg[0]);
    assign cur      = match ? diag_reg + 1'b1 : ((up > left_reg) ? up : left_reg);
    assign sweep_ok = (TGT_W'(cur) >= target_reg);

    always_comb
    begin
        state_next     = state_reg;
        a_line_next    = a_line_reg;
        b_line_next    = b_line_reg;
        row_next       = row_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        drop_next      = drop_reg;
        row_idx_next   = row_idx_reg;
        col_next       = col_reg;
        diag_next      = diag_reg;
        left_next      = left_reg;
        target_next    = target_reg;
        out_valid_next = out_valid_reg && !results.ready;
        reach_next     = reach_reg;
        len_next       = len_reg;
        over_next      = over_reg;
        cmd_pop        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.kind)
                        CMD_APPEND_FIRST:
                        begin
                            cmd_pop = 1'b1;
                            if (m_reg < CNT_W'(MAX_LEN))
                            begin
                                a_line_next[m_reg[IDX_W-1:0]] = cmd.symbol;
                                m_next = m_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        CMD_APPEND_SECOND:
                        begin
                            cmd_pop = 1'b1;
                            if (n_reg < CNT_W'(MAX_LEN))
                            begin
                                b_line_next[n_reg[IDX_W-1:0]] = cmd.symbol;
                                n_next = n_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        CMD_QUERY:
                        begin
                            if (!out_valid_reg || results.ready)
                            begin
                                cmd_pop     = 1'b1;
                                target_next = cmd.target;
                                if (m_reg == '0 || n_reg == '0)
                                begin
                                    out_valid_next = 1'b1;
                                    reach_next     = (cmd.target == '0);
                                    len_next       = (cmd.target == '0)
                                                   ? LEN_W'(m_reg) + LEN_W'(n_reg) : '0;
                                    over_next      = drop_reg;
                                    m_next         = '0;
                                    n_next         = '0;
                                    drop_next      = 1'b0;
                                end
                                else
                                begin
                                    for (int k = 0; k < MAX_LEN; k++)
                                    begin
                                        row_next[k] = '0;
                                    end
                                    row_idx_next = CNT_W'(1);
                                    col_next     = '0;
                                    diag_next    = '0;
                                    left_next    = '0;
                                    state_next   = ST_SWEEP;
                                end
                            end
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_SWEEP:
            begin
                for (int k = 0; k < MAX_LEN - 1; k++)
                begin
                    row_next[k]    = row_reg[k + 1];
                    b_line_next[k] = b_line_reg[k + 1];
                end
                row_next[MAX_LEN-1]    = cur;
                b_line_next[MAX_LEN-1] = b_line_reg[0];
                diag_next = up;
                left_next = cur;
                if (row_idx_reg == m_reg && col_reg == n_reg - 1'b1)
                begin
                    out_valid_next = 1'b1;
                    reach_next     = sweep_ok;
                    len_next       = sweep_ok ? LEN_W'(m_reg) + LEN_W'(n_reg)
                                              - LEN_W'(target_reg) : '0;
                    over_next      = drop_reg;
                    m_next         = '0;
                    n_next         = '0;
                    drop_next      = 1'b0;
                    state_next     = ST_IDLE;
                end
                else if (col_reg == CNT_W'(MAX_LEN - 1))
                begin
                    // advance to the next row of the first string
                    for (int k = 0; k < MAX_LEN - 1; k++)
                    begin
                        a_line_next[k] = a_line_reg[k + 1];
                    end
                    a_line_next[MAX_LEN-1] = a_line_reg[0];
                    col_next     = '0;
                    row_idx_next = row_idx_reg + 1'b1;
                    diag_next    = '0;
                    left_next    = '0;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            m_reg         <= '0;
            n_reg         <= '0;
            drop_reg      <= 1'b0;
            row_idx_reg   <= '0;
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            m_reg         <= m_next;
            n_reg         <= n_next;
            drop_reg      <= drop_next;
            row_idx_reg   <= row_idx_next;
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_line_reg <= a_line_next;
        b_line_reg <= b_line_next;
        row_reg    <= row_next;
        diag_reg   <= diag_next;
        left_reg   <= left_next;
        target_reg <= target_next;
        reach_reg  <= reach_next;
        len_reg    <= len_next;
        over_reg   <= over_next;
    end

    a_row_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (row_idx_reg != '0 && row_idx_reg <= m_reg))
        else $error("sweep row outside first string");

    a_last_row_col: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> (row_idx_reg != m_reg || col_reg < n_reg))
        else $error("sweep ran past the answer cell");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_reg <= CNT_W'(MAX_LEN) && n_reg <= CNT_W'(MAX_LEN)))
        else $error("string count beyond capacity");

    a_no_pop_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SWEEP) |-> !cmd_pop)
        else $error("word taken during sweep");

endmodule

@@ rtl/supersequence_by_common_length_dp_core.sv @@
// Common supersequence check with a required number of shared symbols.
//
// Channels: items (sink) carries operation, symbol and target_common;
// results (source) carries reachable, super_length and overflow. Both use
// valid/ready; a word moves when both are high.
// Operation 0 appends symbol to the first string, 1 to the second, 2 runs a
// query; operation 3 is taken and discarded. Appends past MAX_LEN are dropped
// and reported in overflow of the next result.
// Words go through a decoder into a two-entry queue; the engine drains it.
// Appends: one word per cycle while the queue has room; applied when popped.
// Query with m, n > 0: the engine sweeps an LCS row held in a shift line,
// one column per cycle and MAX_LEN columns per row, and registers the result
// when the sweep reaches column n-1 of row m.
// With m or n zero the engine registers the result without a sweep.
// The queue keeps taking words during a sweep until it is full.
// Reset empties the queue, clears both strings and the overflow flag.
// A stalled result holds in the output register; a further query waits for
// it to drain, and appends behind that query wait in the queue.
module supersequence_by_common_length_dp_core import scl_pkg::*; #(
    parameter int MAX_LEN = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    scl_in_if.sink      items,
    scl_out_if.source   results
);

    logic   push;
    cmd_t   push_cmd;
    logic   full;
    logic   head_valid;
    cmd_t   head_cmd;
    logic   pop;

    scl_front u_front (
        .items    (items),
        .full     (full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    scl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .full       (full),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop)
    );

    scl_engine #(
        .MAX_LEN (MAX_LEN)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (head_valid),
        .cmd       (head_cmd),
        .cmd_pop   (pop),
        .results   (results)
    );

endmodule
